// ----- hdl/ffba_pkg.sv -----
// Shared types and field widths for the first-fit block allocator.
`timescale 1ns / 1ps

package ffba_pkg;

  localparam int unsigned REQ_W   = 13;
  localparam int unsigned HDL_W   = 12;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned BYTES_W = 13;

  typedef enum logic [1:0] {
    OP_ALLOC  = 2'd0,
    OP_FREE   = 2'd1,
    OP_QUERY  = 2'd2,
    OP_REINIT = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NO_FIT = 2'd1,
    ST_BEYOND = 2'd2
  } status_e;

  typedef struct packed {
    op_e                op;
    logic [REQ_W-1:0]   req;
    logic [HDL_W-1:0]   handle;
    logic [POS_W-1:0]   pos;
  } cmd_t;

  typedef struct packed {
    status_e              status;
    logic [OFF_W-1:0]     offset;
    logic [BYTES_W-1:0]   bytes;
    logic                 used;
  } res_t;

endpackage

// ----- hdl/ffba_ram.sv -----
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps

module ffba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ----- hdl/ffba_ctrl.sv -----
// Sequencer that walks, splits and merges the header chain held in the header RAM.
`timescale 1ns / 1ps

module ffba_ctrl #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_POSITION = 255,
  localparam int unsigned AW          = $clog2(ARENA_BYTES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  output logic            cmd_ready_o,
  input  ffba_pkg::cmd_t  cmd_i,
  output logic            res_valid_o,
  input  logic            res_ready_i,
  output ffba_pkg::res_t  res_o,
  output logic            ram_we_o,
  output logic [AW-1:0]   ram_waddr_o,
  output logic [AW:0]     ram_wdata_o,
  output logic [AW-1:0]   ram_raddr_o,
  input  logic [AW:0]     ram_rdata_i
);

  import ffba_pkg::*;

  localparam int unsigned SW = ((AW > BYTES_W) ? AW : BYTES_W) + 2;
  localparam logic [AW-1:0] STOP_OFF = AW'(ARENA_BYTES - HEADER_BYTES);
  localparam logic [SW-1:0] HDR      = SW'(HEADER_BYTES);

  typedef enum logic [8:0] {
    S_LAYOUT0 = 9'b000000001,
    S_LAYOUT1 = 9'b000000010,
    S_IDLE    = 9'b000000100,
    S_ALLOC   = 9'b000001000,
    S_SPLIT   = 9'b000010000,
    S_FHEAD   = 9'b000100000,
    S_FMERGE  = 9'b001000000,
    S_QUERY   = 9'b010000000,
    S_DONE    = 9'b100000000
  } state_e;

  state_e             state_q, state_d;
  logic               init_res_q, init_res_d;
  logic [AW-1:0]      cur_q, cur_d;
  logic [AW-1:0]      nx_q, nx_d;
  logic [AW-1:0]      nb_q, nb_d;
  logic [POS_W-1:0]   cnt_q, cnt_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [REQ_W-1:0]   req_q, req_d;
  res_t               res_q, res_d;

  logic [AW-1:0]      rd_next;
  logic               rd_used;
  logic               lk;
  logic [SW-1:0]      span;
  logic               wrap;
  logic [SW-1:0]      diff;
  logic [SW-1:0]      sz;
  logic               big;
  logic [SW-1:0]      req_ext;
  logic               fit;
  logic               split;
  logic [SW-1:0]      nb_sum;
  logic [AW-1:0]      merged;
  logic [31:0]        cmd_hdl32;
  logic [31:0]        cur32;

  function automatic logic link_ok(input logic [AW-1:0] src, input logic [AW-1:0] dst);
    return (dst != '0) && (dst > src) && (32'(dst) < 32'(ARENA_BYTES));
  endfunction

  assign rd_next   = ram_rdata_i[AW-1:0];
  assign rd_used   = ram_rdata_i[AW];
  assign cmd_hdl32 = 32'(cmd_i.handle);
  assign cur32     = 32'(cur_q);

  // payload of the header just read at cur_q; merged is the onward link of the header at nx_q
  always_comb begin
    lk      = link_ok(cur_q, rd_next);
    span    = SW'(rd_next) - SW'(cur_q);
    wrap    = span < HDR;
    diff    = span - HDR;
    sz      = lk ? diff : '0;
    big     = lk && wrap;
    req_ext = SW'(req_q);
    fit     = !rd_used && (big || (sz >= req_ext));
    split   = big || (sz >= (req_ext + HDR));
    nb_sum  = SW'(cur_q) + HDR + req_ext;
    merged  = link_ok(nx_q, rd_next) ? rd_next : '0;
  end

  always_comb begin
    state_d     = state_q;
    init_res_d  = init_res_q;
    cur_d       = cur_q;
    nx_d        = nx_q;
    nb_d        = nb_q;
    cnt_d       = cnt_q;
    pos_d       = pos_q;
    req_d       = req_q;
    res_d       = res_q;
    cmd_ready_o = 1'b0;
    res_valid_o = 1'b0;
    ram_we_o    = 1'b0;
    ram_waddr_o = cur_q;
    ram_wdata_o = ram_rdata_i;
    ram_raddr_o = cur_q;

    unique case (state_q)
      S_LAYOUT0: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = '0;
        ram_wdata_o = {1'b0, STOP_OFF};
        state_d     = S_LAYOUT1;
      end
      S_LAYOUT1: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = STOP_OFF;
        ram_wdata_o = {1'b1, {AW{1'b0}}};
        res_d       = '{status: ST_OK, offset: '0, bytes: '0, used: 1'b0};
        state_d     = init_res_q ? S_DONE : S_IDLE;
        init_res_d  = 1'b0;
      end
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        ram_raddr_o = (cmd_i.op == OP_FREE) ? cmd_hdl32[AW-1:0] : '0;
        if (cmd_valid_i) begin
          req_d = cmd_i.req;
          pos_d = cmd_i.pos;
          cnt_d = '0;
          cur_d = (cmd_i.op == OP_FREE) ? cmd_hdl32[AW-1:0] : '0;
          res_d = '{status: ST_OK, offset: '0, bytes: '0, used: 1'b0};
          unique case (cmd_i.op)
            OP_ALLOC: state_d = S_ALLOC;
            OP_FREE: begin
              state_d = (cmd_hdl32 < 32'(ARENA_BYTES)) ? S_FHEAD : S_DONE;
            end
            OP_QUERY: begin
              if (32'(cmd_i.pos) > 32'(MAX_POSITION)) begin
                res_d.status = ST_BEYOND;
                state_d      = S_DONE;
              end else begin
                state_d = S_QUERY;
              end
            end
            OP_REINIT: begin
              init_res_d = 1'b1;
              state_d    = S_LAYOUT0;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_ALLOC: begin
        if (fit) begin
          ram_we_o     = 1'b1;
          ram_waddr_o  = cur_q;
          ram_wdata_o  = {1'b1, split ? nb_sum[AW-1:0] : rd_next};
          res_d.status = ST_OK;
          res_d.offset = cur32[OFF_W-1:0];
          res_d.bytes  = split ? req_q : sz[BYTES_W-1:0];
          res_d.used   = 1'b1;
          nb_d         = nb_sum[AW-1:0];
          nx_d         = rd_next;
          state_d      = split ? S_SPLIT : S_DONE;
        end else if (lk) begin
          // advance one link, read of the successor issued now
          ram_raddr_o = rd_next;
          cur_d       = rd_next;
        end else begin
          res_d.status = ST_NO_FIT;
          state_d      = S_DONE;
        end
      end
      S_SPLIT: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = nb_q;
        ram_wdata_o = {1'b0, nx_q};
        state_d     = S_DONE;
      end
      S_FHEAD: begin
        if (lk) begin
          ram_raddr_o = rd_next;
          nx_d        = rd_next;
          state_d     = S_FMERGE;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = cur_q;
          ram_wdata_o = {1'b0, rd_next};
          state_d     = S_DONE;
        end
      end
      S_FMERGE: begin
        if (rd_used) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = cur_q;
          ram_wdata_o = {1'b0, nx_q};
          state_d     = S_DONE;
        end else if (link_ok(cur_q, merged)) begin
          // absorb the free neighbour and look at the one behind it
          ram_raddr_o = merged;
          nx_d        = merged;
        end else begin
          ram_we_o    = 1'b1;
          ram_waddr_o = cur_q;
          ram_wdata_o = {1'b0, merged};
          state_d     = S_DONE;
        end
      end
      S_QUERY: begin
        if (cnt_q == pos_q) begin
          res_d.status = ST_OK;
          res_d.offset = cur32[OFF_W-1:0];
          res_d.bytes  = lk ? diff[BYTES_W-1:0] : '0;
          res_d.used   = rd_used;
          state_d      = S_DONE;
        end else if (lk) begin
          ram_raddr_o = rd_next;
          cur_d       = rd_next;
          cnt_d       = cnt_q + 1'b1;
        end else begin
          res_d.status = ST_BEYOND;
          state_d      = S_DONE;
        end
      end
      S_DONE: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_LAYOUT0;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_LAYOUT0;
      init_res_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      init_res_q <= init_res_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q <= cur_d;
    nx_q  <= nx_d;
    nb_q  <= nb_d;
    cnt_q <= cnt_d;
    pos_q <= pos_d;
    req_q <= req_d;
    res_q <= res_d;
  end

  a_alloc_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ALLOC && state_d == S_ALLOC) |=> (cur_q > $past(cur_q)))
    else $error("allocate walk did not move forward");

  a_merge_forward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FMERGE && state_d == S_FMERGE) |=> (nx_q > $past(nx_q)))
    else $error("merge did not move the link forward");

  a_split_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SPLIT) |-> (nb_q > cur_q && nb_q < nx_q))
    else $error("split header outside its block");

  a_query_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_QUERY) |-> (cnt_q <= pos_q))
    else $error("query walked past the requested position");

endmodule

// ----- hdl/first_fit_block_allocator.sv -----
// Top level of the first-fit block allocator: stream ports, header RAM and result register.
`timescale 1ns / 1ps

// First-fit allocator over an arena of ARENA_BYTES bytes, kept as a chain of
// headers in a RAM with one entry per byte offset (used mark and next link).
// Slave stream: tuser carries the operation (allocate, free, query, reinit),
// tdata the request size, the handle and the chain position. Master stream:
// tuser carries the status, tdata the block offset, payload size and used mark.
// Every command gives exactly one result transfer.
// Per command: allocate walks the chain block by block and may split the block
// it takes; free merges the free neighbours behind the block, and a handle
// outside the arena is answered without reading the chain; query walks to the
// position, and an out-of-range position is answered without a walk; reinit lays out the chain anew.
// The rate is set by the header RAM: one link is followed per read, and the
// registered RAM read data is covered by issuing the next read straight
// from the returned link. One command is in flight at a time.
// After reset the start and end headers are written (S_LAYOUT0, S_LAYOUT1)
// before the first command is taken. A stalled master holds its result in the output
// register while the next command is already worked on; that command then
// waits for the register to drain before its own result is handed over.
module first_fit_block_allocator #(
  parameter int unsigned ARENA_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16,
  parameter int unsigned MAX_POSITION = 255
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // request_bytes [12:0], handle [24:13], position [32:25], zero [39:33]
  input  logic [39:0] s_axis_tdata_i,
  // op [1:0]
  input  logic [1:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // block_offset [11:0], block_bytes [24:12], block_used [25], zero [31:26]
  output logic [31:0] m_axis_tdata_o,
  // status [1:0]
  output logic [1:0]  m_axis_tuser_o
);

  import ffba_pkg::*;

  localparam int unsigned AW = $clog2(ARENA_BYTES);

  cmd_t           cmd;
  res_t           res;
  logic           res_valid;
  logic           res_ready;
  res_t           out_q;
  logic           out_valid_q;

  logic           ram_we;
  logic [AW-1:0]  ram_waddr;
  logic [AW:0]    ram_wdata;
  logic [AW-1:0]  ram_raddr;
  logic [AW:0]    ram_rdata;

  assign cmd.op     = op_e'(s_axis_tuser_i);
  assign cmd.req    = s_axis_tdata_i[12:0];
  assign cmd.handle = s_axis_tdata_i[24:13];
  assign cmd.pos    = s_axis_tdata_i[32:25];

  ffba_ctrl #(
    .ARENA_BYTES  (ARENA_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_POSITION (MAX_POSITION)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (s_axis_tvalid_i),
    .cmd_ready_o (s_axis_tready_o),
    .cmd_i       (cmd),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_raddr_o (ram_raddr),
    .ram_rdata_i (ram_rdata)
  );

  ffba_ram #(
    .WIDTH (AW + 1),
    .DEPTH (ARENA_BYTES)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // take a new result when the register is empty or being drained
  assign res_ready = !out_valid_q || m_axis_tready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b0, out_q.used, out_q.bytes, out_q.offset};
  assign m_axis_tuser_o  = out_q.status;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the first-fit block allocator: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_top;
  import ffba_pkg::*;

  localparam int ARENA   = 4096;
  localparam int HDR     = 16;
  localparam int MAX_POS = 255;
  localparam int SENT    = ARENA - HDR;
  localparam int N_RAND  = 680;
  localparam int DRAIN   = 300;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_axis_tvalid_o;
  logic        m_tready = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  first_fit_block_allocator #(
    .ARENA_BYTES (ARENA),
    .HEADER_BYTES(HDR),
    .MAX_POSITION(MAX_POS)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the header chain: next link and used mark per byte offset.
  int link_mem [ARENA];
  bit used_mem [ARENA];
  bit written  [ARENA];
  int written_q [$];
  int live_q [$];

  res_t expected_q [$];
  int   fail_cnt;
  int   op_cnt [4];
  int   nofit_cnt;
  int   beyond_cnt;
  int   idle_level;
  bit   hold_long;

  typedef struct {
    op_e  op;
    int   req;
    int   hnd;
    int   pos;
    bit   fixed;
    res_t res;
  } row_t;

  row_t dir_rows [$];

  function automatic bit link_fwd(int from, int to);
    return to != 0 && to > from && to < ARENA;
  endfunction

  function automatic int payload(int off);
    return link_fwd(off, link_mem[off]) ? link_mem[off] - off - HDR : 0;
  endfunction

  function automatic void note_header(int off);
    if (!written[off]) begin
      written[off] = 1'b1;
      written_q.push_back(off);
    end
  endfunction

  function automatic void lay_out();
    link_mem[0] = SENT;
    used_mem[0] = 1'b0;
    link_mem[SENT] = 0;
    used_mem[SENT] = 1'b1;
    note_header(0);
    note_header(SENT);
  endfunction

  // Apply one command to the shadow chain and return the result it must produce.
  function automatic res_t chain_result(op_e op, int req, int hnd, int pos);
    res_t r;
    int   cur;
    int   steps;
    int   sz;
    int   nx;
    int   nb;
    bit   found;
    bit   ok;
    r = '0;
    cur = 0;
    steps = 0;
    found = 1'b0;
    case (op)
      OP_ALLOC: begin
        while (1) begin
          sz = payload(cur);
          if (!used_mem[cur] && sz >= req) begin
            found = 1'b1;
            break;
          end
          steps++;
          if (!link_fwd(cur, link_mem[cur]) || steps >= ARENA) break;
          cur = link_mem[cur];
        end
        if (found) begin
          sz = payload(cur);
          // split only when a fresh header fits behind the request
          if (sz >= req + HDR) begin
            nb = cur + HDR + req;
            link_mem[nb] = link_mem[cur];
            used_mem[nb] = 1'b0;
            note_header(nb);
            link_mem[cur] = nb;
            sz = req;
          end
          used_mem[cur] = 1'b1;
          r.offset = OFF_W'(cur);
          r.bytes = BYTES_W'(sz);
          r.used = 1'b1;
        end else begin
          r.status = ST_NO_FIT;
        end
      end
      OP_FREE: begin
        used_mem[hnd] = 1'b0;
        while (steps < ARENA) begin
          nx = link_mem[hnd];
          if (!link_fwd(hnd, nx) || used_mem[nx]) break;
          link_mem[hnd] = link_fwd(nx, link_mem[nx]) ? link_mem[nx] : 0;
          steps++;
        end
      end
      OP_QUERY: begin
        ok = pos <= MAX_POS;
        while (ok && steps < pos) begin
          if (!link_fwd(cur, link_mem[cur])) begin
            ok = 1'b0;
          end else begin
            cur = link_mem[cur];
            steps++;
          end
        end
        if (ok) begin
          r.offset = OFF_W'(cur);
          r.bytes = BYTES_W'(payload(cur));
          r.used = used_mem[cur];
        end else begin
          r.status = ST_BEYOND;
        end
      end
      default: lay_out();
    endcase
    return r;
  endfunction

  task automatic add_row(op_e op, int req, int hnd, int pos, bit fixed,
                         status_e st, int off, int nbytes, bit used);
    row_t row;
    row.op = op;
    row.req = req;
    row.hnd = hnd;
    row.pos = pos;
    row.fixed = fixed;
    row.res.status = st;
    row.res.offset = OFF_W'(off);
    row.res.bytes = BYTES_W'(nbytes);
    row.res.used = used;
    dir_rows.push_back(row);
  endtask

  // Offer one command, hold it until the transfer, then book its expected result.
  task automatic send_cmd(op_e op, int req, int hnd, int pos, bit fixed, res_t fixed_res,
                          output res_t pred);
    s_tuser <= op;
    s_tdata <= {7'd0, pos[7:0], hnd[11:0], req[12:0]};
    s_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    pred = chain_result(op, req, hnd, pos);
    expected_q.push_back(fixed ? fixed_res : pred);
    op_cnt[op]++;
    if (op == OP_ALLOC && pred.status == ST_OK) live_q.push_back(pred.offset);
    if (op == OP_REINIT) live_q.delete();
    if (idle_level != 0 && $urandom_range(0, idle_level == 1 ? 7 : 1) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 15)) @(posedge clk_i);
    end
  endtask

  // Result side: random stall bursts plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_long) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk_i);
        hold_long = 1'b0;
        m_tready <= 1'b1;
      end else if (idle_level != 0 &&
                   $urandom_range(0, idle_level == 1 ? 15 : 3) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 15)) @(posedge clk_i);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  res_t        want;
  logic [11:0] got_off;
  logic [12:0] got_bytes;

  always @(posedge clk_i) begin
    if (m_axis_tvalid_o && m_tready) begin
      got_off = m_axis_tdata_o[11:0];
      got_bytes = m_axis_tdata_o[24:12];
      if (expected_q.size() == 0) begin
        $error("unexpected result transfer: status %0d offset %0d", m_axis_tuser_o, got_off);
        fail_cnt++;
      end else begin
        want = expected_q.pop_front();
        if (want.status == ST_NO_FIT) nofit_cnt++;
        if (want.status == ST_BEYOND) beyond_cnt++;
        if (m_axis_tuser_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, m_axis_tuser_o);
          fail_cnt++;
        end
        if (got_off !== want.offset) begin
          $error("block_offset: expected %0d, got %0d", want.offset, got_off);
          fail_cnt++;
        end
        if (got_bytes !== want.bytes) begin
          $error("block_bytes: expected %0d, got %0d", want.bytes, got_bytes);
          fail_cnt++;
        end
        if (m_axis_tdata_o[25] !== want.used) begin
          $error("block_used: expected %0d, got %0d", want.used, m_axis_tdata_o[25]);
          fail_cnt++;
        end
      end
    end
  end

  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    res_t pred;
    int   r;
    int   idx;
    op_e  op;
    int   req;
    int   hnd;
    int   pos;
    lay_out();
    idle_level = 1;
    hold_long = 1'b0;

    // after reset: one free block spanning the arena, then the end header
    add_row(OP_QUERY,     0,    0,   0, 1'b1, ST_OK,     0,    4064, 1'b0);
    add_row(OP_QUERY,     0,    0,   1, 1'b1, ST_OK,     SENT, 0,    1'b1);
    add_row(OP_QUERY,     0,    0,   2, 1'b1, ST_BEYOND, 0,    0,    1'b0);
    add_row(OP_QUERY,     0,    0, 255, 1'b1, ST_BEYOND, 0,    0,    1'b0);
    add_row(OP_ALLOC,  4096,    0,   0, 1'b1, ST_NO_FIT, 0,    0,    1'b0);
    add_row(OP_ALLOC,  4064,    0,   0, 1'b1, ST_OK,     0,    4064, 1'b1);
    add_row(OP_ALLOC,     0,    0,   0, 1'b1, ST_NO_FIT, 0,    0,    1'b0);
    add_row(OP_FREE,      0,    0,   0, 1'b1, ST_OK,     0,    0,    1'b0);
    add_row(OP_REINIT,    0,    0,   0, 1'b1, ST_OK,     0,    0,    1'b0);
    add_row(OP_ALLOC,     0,    0,   0, 1'b0, ST_OK,     0,    0,    1'b0);
    // no room for a header behind this one: whole block taken
    add_row(OP_ALLOC,  4033,    0,   0, 1'b0, ST_OK,     0,    0,    1'b0);
    add_row(OP_QUERY,     0,    0,   2, 1'b0, ST_OK,     0,    0,    1'b0);
    add_row(OP_FREE,      0,   16,   0, 1'b1, ST_OK,     0,    0,    1'b0);
    add_row(OP_ALLOC,   100,    0,   0, 1'b0, ST_OK,     0,    0,    1'b0);
    add_row(OP_ALLOC,     1,    0,   0, 1'b0, ST_OK,     0,    0,    1'b0);
    add_row(OP_ALLOC,  4096,    0,   0, 1'b1, ST_NO_FIT, 0,    0,    1'b0);
    add_row(OP_FREE,      0,   16,   0, 1'b1, ST_OK,     0,    0,    1'b0);
    add_row(OP_FREE,      0,  132,   0, 1'b1, ST_OK,     0,    0,    1'b0);
    add_row(OP_QUERY,     0,    0,   1, 1'b0, ST_OK,     0,    0,    1'b0);
    // release the end header itself, then try to land on it
    add_row(OP_FREE,      0, SENT,   0, 1'b1, ST_OK,     0,    0,    1'b0);
    add_row(OP_ALLOC,  4000,    0,   0, 1'b0, ST_OK,     0,    0,    1'b0);
    add_row(OP_ALLOC,     0,    0,   0, 1'b0, ST_OK,     0,    0,    1'b0);
    add_row(OP_QUERY,     0,    0, 255, 1'b1, ST_BEYOND, 0,    0,    1'b0);
    // stale header that an earlier merge swallowed
    add_row(OP_FREE,      0,  149,   0, 1'b1, ST_OK,     0,    0,    1'b0);
    add_row(OP_REINIT,    0,    0,   0, 1'b1, ST_OK,     0,    0,    1'b0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_cmd(dir_rows[i].op, dir_rows[i].req, dir_rows[i].hnd, dir_rows[i].pos,
               dir_rows[i].fixed, dir_rows[i].res, pred);
    end

    for (int i = 0; i < N_RAND; i++) begin
      idle_level = (i < N_RAND - 100) ? (i / 80) % 3 : 0;
      if (i == 150) hold_long = 1'b1;
      req = 0;
      hnd = 0;
      pos = $urandom_range(0, 255);
      idx = -1;
      r = $urandom_range(0, 99);
      if (r < 3) begin
        op = OP_REINIT;
      end else if (r < 45 || (r < 72 && live_q.size() == 0 && $urandom_range(0, 3) != 0)) begin
        op = OP_ALLOC;
        r = $urandom_range(0, 99);
        if (r < 60) req = $urandom_range(0, 48);
        else if (r < 85) req = $urandom_range(0, 300);
        else if (r < 97) req = $urandom_range(0, 4096);
        else req = 4096;
      end else if (r < 72) begin
        op = OP_FREE;
        // mostly live handles; now and then any offset that once held a header
        if (live_q.size() != 0 && $urandom_range(0, 9) != 0) begin
          idx = $urandom_range(0, live_q.size() - 1);
          hnd = live_q[idx];
        end else begin
          hnd = written_q[$urandom_range(0, written_q.size() - 1)];
        end
      end else begin
        op = OP_QUERY;
        if ($urandom_range(0, 3) != 0) pos = $urandom_range(0, live_q.size() + 3);
      end
      req = req | ($urandom_range(0, 1) ? 0 : 0);
      send_cmd(op, req, hnd, pos, 1'b0, '0, pred);
      if (idx >= 0) live_q.delete(idx);
    end
    s_tvalid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);

    $display("Ran %0d commands: %0d allocate, %0d free, %0d query, %0d reinit.",
             op_cnt.sum(),
             op_cnt[OP_ALLOC], op_cnt[OP_FREE], op_cnt[OP_QUERY], op_cnt[OP_REINIT]);
    $display("Saw %0d no-fit allocations and %0d queries past the chain end.",
             nofit_cnt, beyond_cnt);
    if (fail_cnt == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/ffba_pkg.sv
hdl/ffba_ram.sv
hdl/ffba_ctrl.sv
hdl/first_fit_block_allocator.sv
tb/tb_top.sv
